// ===== hw/rtl/natab_pkg.sv =====
// Shared types and codes for the address-translation table.
// Depends on nothing; used by the top level nat_address_table.
package natab_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int OCC_W  = 5;
  localparam int IN_W   = 144;
  localparam int OUT_W  = 120;

  // One table entry as it is stored in the entry memory.
  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  virtual_ip;
    logic [IP_W-1:0]  real_ip;
  } entry_t;

endpackage

// ===== hw/rtl/nat_address_table.sv =====
// Address-translation table: insertion-ordered entries, newest-first search.
// Depends on natab_pkg and natab_ram.
//
// Insert and clear, and lookup or delete on an empty table, go from the start step
// straight to the result step. Lookup and delete scan one entry per cycle through
// the entry memory read port, newest first. Delete then moves each newer entry
// down one slot, one per cycle. One operation at a time; the next word is taken
// the cycle after the result is raised, and a finished result waits in the output
// register. Synchronous reset empties the table (the fill count marks valid entries).
module nat_address_table #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key_ip[31:0], new_real_ip[63:32], new_virtual_ip[95:64], new_mac[143:96]
  input  logic [143:0] s_tdata,
  // op[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_real_ip[31:0], hit_virtual_ip[63:32], hit_mac[111:64], status[113:112],
  // occupancy[118:114], zero pad[119]
  output logic [119:0] m_tdata,
  // found[0]
  output logic         m_tuser
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t                    state;
  natab_pkg::op_t            op_q;
  logic [natab_pkg::IP_W-1:0] key_q;
  natab_pkg::entry_t         new_entry_q;
  logic [CW-1:0]             cnt;
  logic [AW-1:0]             scan_idx;
  logic                      pend_v;
  logic [AW-1:0]             pend_idx;
  logic [CW-1:0]             sh_idx;
  logic                      wv;
  logic [AW-1:0]             wa;
  logic                      res_found;
  natab_pkg::status_t        res_status;
  natab_pkg::entry_t         hit_entry;

  logic                      out_found;
  natab_pkg::entry_t         out_entry;
  natab_pkg::status_t        out_status;
  logic [natab_pkg::OCC_W-1:0] out_occ;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  natab_pkg::entry_t         wr_data;
  logic [AW-1:0]             rd_addr;
  natab_pkg::entry_t         rd_data;
  logic                      match;
  logic                      shift_issue;
  logic [CW+natab_pkg::OCC_W-1:0] cnt_ext;

  natab_ram #(
    .WIDTH ($bits(natab_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slots 0 .. cnt-1 are valid, oldest in slot 0, so insert appends at cnt
  // and the scan runs downward from the newest slot.
  assign match = pend_v && ((rd_data.real_ip == key_q) || (rd_data.virtual_ip == key_q));
  assign shift_issue = (sh_idx < cnt);
  assign cnt_ext = (CW + natab_pkg::OCC_W)'(cnt);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wa;
    wr_data = rd_data;
    rd_addr = scan_idx;
    if (state == ST_START && op_q == natab_pkg::OP_INSERT && cnt != FULL_COUNT) begin
      wr_en   = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_data = new_entry_q;
    end else if (state == ST_SHIFT) begin
      wr_en   = wv;
      rd_addr = sh_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      pend_v   <= 1'b0;
      wv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // In the result step the output word is reloaded below instead.
      if (m_tvalid && m_tready && state != ST_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_q                   <= natab_pkg::op_t'(s_tuser);
            key_q                  <= s_tdata[31:0];
            new_entry_q.real_ip    <= s_tdata[63:32];
            new_entry_q.virtual_ip <= s_tdata[95:64];
            new_entry_q.mac        <= s_tdata[143:96];
            state                  <= ST_START;
          end
        end
        ST_START: begin
          pend_v     <= 1'b0;
          wv         <= 1'b0;
          res_found  <= 1'b0;
          res_status <= natab_pkg::STATUS_DONE;
          hit_entry  <= '0;
          unique case (op_q)
            natab_pkg::OP_LOOKUP, natab_pkg::OP_DELETE: begin
              if (cnt == '0) begin
                res_status <= natab_pkg::STATUS_MISS;
                state      <= ST_RESULT;
              end else begin
                scan_idx <= AW'(cnt - CW'(1));
                state    <= ST_SCAN;
              end
            end
            natab_pkg::OP_INSERT: begin
              if (cnt == FULL_COUNT) begin
                res_status <= natab_pkg::STATUS_FULL;
              end else begin
                cnt <= cnt + CW'(1);
              end
              state <= ST_RESULT;
            end
            natab_pkg::OP_CLEAR: begin
              cnt   <= '0;
              state <= ST_RESULT;
            end
          endcase
        end
        ST_SCAN: begin
          // A read goes out every cycle; the compare sees the slot read in the
          // cycle before. Slot 0 may be read again after the last step.
          pend_v   <= 1'b1;
          pend_idx <= scan_idx;
          if (scan_idx != '0) begin
            scan_idx <= scan_idx - AW'(1);
          end
          if (match) begin
            res_found <= 1'b1;
            hit_entry <= rd_data;
            if (op_q == natab_pkg::OP_DELETE) begin
              sh_idx <= CW'(pend_idx) + CW'(1);
              wv     <= 1'b0;
              state  <= ST_SHIFT;
            end else begin
              state <= ST_RESULT;
            end
          end else if (pend_v && pend_idx == '0) begin
            res_status <= natab_pkg::STATUS_MISS;
            state      <= ST_RESULT;
          end
        end
        ST_SHIFT: begin
          // Read slot sh_idx now, write it one slot lower next cycle.
          wv <= shift_issue;
          wa <= AW'(sh_idx - CW'(1));
          if (shift_issue) begin
            sh_idx <= sh_idx + CW'(1);
          end
          if (!shift_issue && !wv) begin
            cnt   <= cnt - CW'(1);
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_found  <= res_found;
            out_entry  <= hit_entry;
            out_status <= res_status;
            out_occ    <= cnt_ext[natab_pkg::OCC_W-1:0];
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tuser  = out_found;
  assign m_tdata  = {1'b0, out_occ, out_status, out_entry.mac,
                     out_entry.virtual_ip, out_entry.real_ip};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_COUNT)
    else $error("entry count exceeds table size");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_START || state == ST_SHIFT))
    else $error("entry memory written outside insert or shift");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (cnt != $past(cnt)) |-> ($past(state) == ST_START || $past(state) == ST_SHIFT))
    else $error("entry count changed outside an operation step");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_found) |-> (out_status == natab_pkg::STATUS_DONE))
    else $error("hit reported with a failure status");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_RESULT))
    else $error("result word raised outside the result step");

endmodule

// ===== hw/rtl/natab_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the table entries of nat_address_table.
module natab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== verif/nat_address_table_check.sv =====
// Checker for the address-translation table: watches both stream channels,
// predicts every result word from its own copy of the table, and compares.
// Depends on natab_pkg for the operation and status codes and the entry layout.
`timescale 1ns / 100ps

module nat_address_table_check #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic         m_tuser,
  output int           mismatches,
  output int           outstanding
);

  typedef struct packed {
    logic                          found;
    logic [natab_pkg::IP_W-1:0]    real_ip;
    logic [natab_pkg::IP_W-1:0]    virtual_ip;
    logic [natab_pkg::MAC_W-1:0]   mac;
    natab_pkg::status_t            status;
    logic [natab_pkg::OCC_W-1:0]   occupancy;
  } reply_t;

  // Slot 0 holds the newest entry; slots 0 .. fill-1 are valid.
  natab_pkg::entry_t slots [ENTRIES];
  int     fill;
  reply_t replies_due [$];

  function automatic reply_t apply_table_op(input natab_pkg::op_t op,
                                            input logic [natab_pkg::IP_W-1:0] key,
                                            input natab_pkg::entry_t fresh);
    reply_t r;
    int     hit;
    int     i;
    r = '0;
    r.status = natab_pkg::STATUS_DONE;
    case (op)
      natab_pkg::OP_LOOKUP, natab_pkg::OP_DELETE: begin
        hit = -1;
        for (i = 0; i < fill; i++) begin
          if (hit < 0 && (slots[i].real_ip == key || slots[i].virtual_ip == key)) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = natab_pkg::STATUS_MISS;
        end else begin
          r.found      = 1'b1;
          r.real_ip    = slots[hit].real_ip;
          r.virtual_ip = slots[hit].virtual_ip;
          r.mac        = slots[hit].mac;
          if (op == natab_pkg::OP_DELETE) begin
            for (i = hit; i + 1 < fill; i++) begin
              slots[i] = slots[i + 1];
            end
            fill--;
          end
        end
      end
      natab_pkg::OP_INSERT: begin
        if (fill >= ENTRIES) begin
          r.status = natab_pkg::STATUS_FULL;
        end else begin
          for (i = fill; i > 0; i--) begin
            slots[i] = slots[i - 1];
          end
          slots[0] = fresh;
          fill++;
        end
      end
      default: begin
        fill = 0;
      end
    endcase
    r.occupancy = fill[natab_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic log_mismatch(input string why, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, why);
      $display("  expected found=%0d real=%h virt=%h mac=%h status=%0d occ=%0d",
               want.found, want.real_ip, want.virtual_ip, want.mac, want.status,
               want.occupancy);
      $display("  actual   found=%0d real=%h virt=%h mac=%h status=%0d occ=%0d",
               got.found, got.real_ip, got.virtual_ip, got.mac, got.status, got.occupancy);
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    natab_pkg::entry_t fresh;
    if (rst) begin
      fill = 0;
      replies_due.delete();
    end else begin
      // Results on the output always belong to words accepted earlier, so
      // they are checked before this cycle's input word is predicted.
      if (m_tvalid && m_tready) begin
        got.found      = m_tuser;
        got.real_ip    = m_tdata[31:0];
        got.virtual_ip = m_tdata[63:32];
        got.mac        = m_tdata[111:64];
        got.status     = natab_pkg::status_t'(m_tdata[113:112]);
        got.occupancy  = m_tdata[118:114];
        if (replies_due.size() == 0) begin
          log_mismatch("result word with no operation pending", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got.found !== want.found || got.real_ip !== want.real_ip ||
              got.virtual_ip !== want.virtual_ip || got.mac !== want.mac ||
              got.status !== want.status || got.occupancy !== want.occupancy) begin
            log_mismatch("result word differs", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fresh.real_ip    = s_tdata[63:32];
        fresh.virtual_ip = s_tdata[95:64];
        fresh.mac        = s_tdata[143:96];
        replies_due.push_back(apply_table_op(natab_pkg::op_t'(s_tuser), s_tdata[31:0],
                                             fresh));
      end
    end
    outstanding = replies_due.size();
  end

endmodule

// ===== verif/nat_address_table_test.sv =====
// Top of the address-translation table testbench: clock, reset, stimulus and
// verdict. Depends on natab_pkg, nat_address_table and nat_address_table_check.
`timescale 1ns / 100ps

module nat_address_table_test;

  localparam int ENTRIES = 16;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic         m_tuser;

  logic         in_took = 1'b0;
  int           mismatches;
  int           outstanding;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_req;
  logic [natab_pkg::IP_W-1:0] addr_pool [32];

  nat_address_table #(.ENTRIES(ENTRIES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  nat_address_table_check #(.ENTRIES(ENTRIES)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Handshake seen at the last rising edge, read back at the falling edge.
  always @(posedge clk) begin
    in_took <= s_tvalid && s_tready;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic natab_pkg::entry_t make_entry(
      input logic [natab_pkg::IP_W-1:0]  real_ip,
      input logic [natab_pkg::IP_W-1:0]  virtual_ip,
      input logic [natab_pkg::MAC_W-1:0] mac);
    natab_pkg::entry_t e;
    e.real_ip    = real_ip;
    e.virtual_ip = virtual_ip;
    e.mac        = mac;
    return e;
  endfunction

  // Addresses from a small pool at the given percentage, so lookups and deletes find entries.
  function automatic logic [natab_pkg::IP_W-1:0] pick_addr(input int pool_pct);
    if ($urandom_range(99) < pool_pct) begin
      return addr_pool[$urandom_range(31)];
    end
    return $urandom;
  endfunction

  function automatic natab_pkg::entry_t random_entry(input int pool_pct);
    return make_entry(pick_addr(pool_pct), pick_addr(pool_pct), {16'($urandom), $urandom});
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input natab_pkg::op_t op, input logic [natab_pkg::IP_W-1:0] key,
                           input natab_pkg::entry_t fresh);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {fresh.mac, fresh.virtual_ip, fresh.real_ip, key};
    @(negedge clk);
    while (!in_took) begin
      @(negedge clk);
    end
  endtask

  task automatic send_random_word();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      send_word(natab_pkg::op_t'($urandom_range(3)), $urandom, random_entry(0));
    end else if (r < 12) begin
      send_word(natab_pkg::OP_CLEAR, pick_addr(50), random_entry(0));
    end else if (r < 52) begin
      send_word(natab_pkg::OP_INSERT, $urandom, random_entry(80));
    end else if (r < 78) begin
      send_word(natab_pkg::OP_LOOKUP, pick_addr(85), random_entry(0));
    end else begin
      send_word(natab_pkg::OP_DELETE, pick_addr(85), random_entry(0));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : receiver
    int seen;
    seen = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        m_tready <= 1'b0;
        repeat (299) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = natab_pkg::OP_LOOKUP;
    s_tdata = '0;
    send_idle_pct = 7;
    recv_idle_pct = 66;
    hold_req = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (i = 2; i < 32; i++) begin
      addr_pool[i] = $urandom;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: misses and a clear with nothing in it.
    send_word(natab_pkg::OP_LOOKUP, '0, random_entry(0));
    send_word(natab_pkg::OP_DELETE, '1, random_entry(0));
    send_word(natab_pkg::OP_CLEAR, '1, random_entry(0));
    // Extreme addresses; key 0 then matches the newest entry by its virtual address.
    send_word(natab_pkg::OP_INSERT, '0, make_entry('0, '1, '0));
    send_word(natab_pkg::OP_INSERT, '1, make_entry('1, '0, '1));
    send_word(natab_pkg::OP_LOOKUP, '0, random_entry(0));
    // Duplicate addresses: only the newest copy is seen and removed.
    send_word(natab_pkg::OP_INSERT, '0,
              make_entry(32'h0a00_0001, 32'hc0a8_0001, 48'h0000_5e00_0001));
    send_word(natab_pkg::OP_INSERT, '0,
              make_entry(32'h0a00_0001, 32'hc0a8_0001, 48'h0000_5e00_0002));
    send_word(natab_pkg::OP_LOOKUP, 32'hc0a8_0001, random_entry(0));
    send_word(natab_pkg::OP_DELETE, 32'h0a00_0001, random_entry(0));
    // Delete from the middle of the table.
    send_word(natab_pkg::OP_DELETE, '0, random_entry(0));
    // Fill the table, then an insert that must be refused.
    repeat (14) send_word(natab_pkg::OP_INSERT, $urandom, random_entry(50));
    send_word(natab_pkg::OP_INSERT, $urandom, random_entry(0));
    send_word(natab_pkg::OP_DELETE, '0, random_entry(0));
    send_word(natab_pkg::OP_CLEAR, '0, random_entry(0));

    for (i = 0; i < 3; i++) begin
      drain();
      send_idle_pct = (i == 1) ? 66 : 0;
      recv_idle_pct = (i == 0) ? 66 : 7;
      if (i == 2) begin
        recv_idle_pct = 0;
        // Long receiver hold-off while words keep coming, to back up the input.
        hold_req++;
      end else if (i == 0) begin
        send_idle_pct = 7;
      end
      repeat (267) send_random_word();
    end

    drain();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
